FILE: src/tabbt_pkg.sv
// ----------------------------------------------------------------------------
// tabbt_pkg
// Shared types and constants of the triangular A*B*B^T + A^T*A engine.
// ----------------------------------------------------------------------------
package tabbt_pkg;

	localparam int MAX_SIZE_DEF = 16;
	localparam int FUNC_W       = 2;
	localparam int IDX_W        = 4;
	localparam int VAL_W        = 16;
	localparam int STAT_W       = 2;
	localparam int DATA_W       = 64;
	localparam int CFG_W        = 5;
	localparam int AB_W         = 36;
	localparam logic [CFG_W-1:0] SIZE_RST = CFG_W'(16);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WR_A  = 2'd0,
		FUNC_WR_B  = 2'd1,
		FUNC_START = 2'd2,
		FUNC_RD_C  = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_WR_OK = 2'd0,
		ST_DONE  = 2'd1,
		ST_RD_OK = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_PH1,
		SEQ_DRAIN,
		SEQ_PH2,
		SEQ_FLUSH
	} seq_state_t;

	// one issued multiply-accumulate step
	typedef struct packed {
		logic valid;
		logic phase2;
		logic first;
		logic last;
		logic term_en;
	} mac_ctl_t;

endpackage

FILE: src/tabbt_req_if.sv
// ----------------------------------------------------------------------------
// tabbt_req_if
// Request channel: function code, element indices and write value.
// ----------------------------------------------------------------------------
interface tabbt_req_if import tabbt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [FUNC_W-1:0]       func;
	logic [IDX_W-1:0]        row;
	logic [IDX_W-1:0]        col;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, func, row, col, value, input ready);
	modport sink (input valid, func, row, col, value, output ready);
endinterface

FILE: src/tabbt_rsp_if.sv
// ----------------------------------------------------------------------------
// tabbt_rsp_if
// Response channel: status code and read data.
// ----------------------------------------------------------------------------
interface tabbt_rsp_if import tabbt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] data;

	modport source (output valid, status, data, input ready);
	modport sink (input valid, status, data, output ready);
endinterface

FILE: src/tabbt_cfg_if.sv
// ----------------------------------------------------------------------------
// tabbt_cfg_if
// Configuration write channel for the matrix size register.
// ----------------------------------------------------------------------------
interface tabbt_cfg_if import tabbt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: src/triangular_abbt_plus_ata_engine_unit.sv
// ----------------------------------------------------------------------------
// triangular_abbt_plus_ata_engine_unit
// Element-addressed matrix engine computing C = A*B*B^T + A^T*A.
// ----------------------------------------------------------------------------
//  channel | dir | fields              | transaction
//  req     | in  | func row col value  | write A/B element, start, read C
//  rsp     | out | status data         | one per request
//  cfg     | in  | data                | matrix size, write while idle
//
//  Writes and out-of-range requests answer from the response register; a read
//  of C also passes through the registered read port of the C memory first.
//  Start walks i, j, k twice through the stores, each pass followed by a
//  pipeline drain; one multiply-accumulate per cycle while a pass issues.
//  Requests stall while a computation runs, a read is in flight, or the
//  response register is full and not being taken.
//  Reset clears control only; store contents are undefined until written.
// ----------------------------------------------------------------------------
module triangular_abbt_plus_ata_engine_unit import tabbt_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tabbt_req_if.sink   req,
	tabbt_rsp_if.source rsp,
	tabbt_cfg_if.sink   cfg
);
	localparam int IW    = $clog2(MAX_SIZE);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam int NW    = $clog2(MAX_SIZE + 1);
	localparam int CMP_W = (NW > CFG_W) ? NW : CFG_W;
	localparam int XW    = IW + IDX_W;

	logic [CFG_W-1:0]         size_q;
	logic [CMP_W-1:0]         size_x, n_c;
	logic [IW-1:0]            n_last;
	logic                     busy_q, rd_pend_q;
	logic                     out_valid_q;
	logic [STAT_W-1:0]        out_status_q;
	logic [DATA_W-1:0]        out_data_q;
	logic                     req_acc, in_range;
	logic [XW-1:0]            row_x, col_x;
	logic [AW-1:0]            req_addr;
	logic                     start, seq_done, mac_busy;
	mac_ctl_t                 ctl;
	logic [AW-1:0]            waddr, a0_raddr, a1_raddr, b_raddr, ab_raddr, wr_addr;
	logic [VAL_W-1:0]         a0_rdata, a1_rdata, b_rdata;
	logic [AB_W-1:0]          ab_rdata, ab_wdata;
	logic [DATA_W-1:0]        c_rdata, c_wdata;
	logic                     ab_we, c_we, a_we, b_we;

	// size register; the size in use is clamped to 1..MAX_SIZE
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RST;
		end else if (cfg.valid) begin
			size_q <= cfg.data;
		end
	end

	assign size_x = CMP_W'(size_q);
	always_comb begin
		priority if (size_x == '0) begin
			n_c = CMP_W'(1);
		end else if (size_x > CMP_W'(MAX_SIZE)) begin
			n_c = CMP_W'(MAX_SIZE);
		end else begin
			n_c = size_x;
		end
	end
	assign n_last = IW'(n_c - CMP_W'(1));

	assign row_x    = XW'(req.row);
	assign col_x    = XW'(req.col);
	assign req_addr = {row_x[IW-1:0], col_x[IW-1:0]};
	assign in_range = (CMP_W'(req.row) < n_c) && (CMP_W'(req.col) < n_c);

	assign req.ready = !busy_q && !rd_pend_q && (!out_valid_q || rsp.ready);
	assign req_acc   = req.valid && req.ready;
	assign start     = req_acc && (func_t'(req.func) == FUNC_START);
	assign a_we      = req_acc && in_range && (func_t'(req.func) == FUNC_WR_A);
	assign b_we      = req_acc && in_range && (func_t'(req.func) == FUNC_WR_B);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= req_acc && in_range && (func_t'(req.func) == FUNC_RD_C);
			if (start) begin
				busy_q <= 1'b1;
			end else if (seq_done) begin
				busy_q <= 1'b0;
			end
			if (seq_done || rd_pend_q
					|| (req_acc && !start && !(in_range && func_t'(req.func) == FUNC_RD_C))) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (seq_done) begin
			out_status_q <= ST_DONE;
			out_data_q   <= '0;
		end else if (rd_pend_q) begin
			out_status_q <= ST_RD_OK;
			out_data_q   <= c_rdata;
		end else if (req_acc && !start) begin
			out_status_q <= in_range ? ST_WR_OK : ST_RANGE;
			out_data_q   <= '0;
		end else begin
			out_status_q <= out_status_q;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.data   = out_data_q;

	tabbt_seq #(.MAX_SIZE(MAX_SIZE)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.n_last   (n_last),
		.mac_busy (mac_busy),
		.ctl      (ctl),
		.waddr    (waddr),
		.a0_raddr (a0_raddr),
		.a1_raddr (a1_raddr),
		.b_raddr  (b_raddr),
		.ab_raddr (ab_raddr),
		.done     (seq_done)
	);

	tabbt_mac #(.AW(AW)) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl),
		.waddr_in (waddr),
		.a0_rdata (a0_rdata),
		.a1_rdata (a1_rdata),
		.b_rdata  (b_rdata),
		.ab_rdata (ab_rdata),
		.ab_we    (ab_we),
		.c_we     (c_we),
		.wr_addr  (wr_addr),
		.ab_wdata (ab_wdata),
		.c_wdata  (c_wdata),
		.busy     (mac_busy)
	);

	// two copies of A give the two column reads of A^T*A in the same cycle
	tabbt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a0_ram (
		.clk (clk), .we (a_we), .waddr (req_addr), .wdata (req.value),
		.raddr (a0_raddr), .rdata (a0_rdata)
	);
	tabbt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a1_ram (
		.clk (clk), .we (a_we), .waddr (req_addr), .wdata (req.value),
		.raddr (a1_raddr), .rdata (a1_rdata)
	);
	tabbt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_b_ram (
		.clk (clk), .we (b_we), .waddr (req_addr), .wdata (req.value),
		.raddr (b_raddr), .rdata (b_rdata)
	);
	tabbt_ram #(.WIDTH(AB_W), .DEPTH(DEPTH)) u_ab_ram (
		.clk (clk), .we (ab_we), .waddr (wr_addr), .wdata (ab_wdata),
		.raddr (ab_raddr), .rdata (ab_rdata)
	);
	tabbt_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_c_ram (
		.clk (clk), .we (c_we), .waddr (wr_addr), .wdata (c_wdata),
		.raddr (req_addr), .rdata (c_rdata)
	);

`ifndef SYNTH
	a_no_rd_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && rd_pend_q))
		else $error("C read in flight during computation");
	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		seq_done |-> busy_q)
		else $error("computation done without a start");
	a_store_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ab_we || c_we) |-> busy_q)
		else $error("result store written outside a computation");
	a_rd_answer: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |=> (out_valid_q && out_status_q == ST_RD_OK))
		else $error("C read not answered");
	a_no_input_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !(a_we || b_we))
		else $error("operand written during computation");
`endif
endmodule

FILE: src/tabbt_ram.sv
// ----------------------------------------------------------------------------
// tabbt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tabbt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/tabbt_seq.sv
// ----------------------------------------------------------------------------
// tabbt_seq
// Compute sequencer: walks i, j, k for both product phases and issues reads.
// ----------------------------------------------------------------------------
module tabbt_seq import tabbt_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF,
	localparam int IW = $clog2(MAX_SIZE),
	localparam int AW = 2 * IW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [IW-1:0] n_last,
	input  logic          mac_busy,
	output mac_ctl_t      ctl,
	output logic [AW-1:0] waddr,
	output logic [AW-1:0] a0_raddr,
	output logic [AW-1:0] a1_raddr,
	output logic [AW-1:0] b_raddr,
	output logic [AW-1:0] ab_raddr,
	output logic          done
);
	seq_state_t    state_q, state_d;
	logic [IW-1:0] i_q, j_q, k_q;
	logic          issue, k_end, j_end, i_end, ph_end;

	assign k_end  = (k_q == n_last);
	assign j_end  = (j_q == n_last);
	assign i_end  = (i_q == n_last);
	assign ph_end = k_end && j_end && i_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		done    = 1'b0;
		unique case (state_q)
			SEQ_IDLE: begin
				if (start) state_d = SEQ_PH1;
			end
			SEQ_PH1: begin
				issue = 1'b1;
				if (ph_end) state_d = SEQ_DRAIN;
			end
			// hold until every A*B element is back in its store
			SEQ_DRAIN: begin
				if (!mac_busy) state_d = SEQ_PH2;
			end
			SEQ_PH2: begin
				issue = 1'b1;
				if (ph_end) state_d = SEQ_FLUSH;
			end
			SEQ_FLUSH: begin
				if (!mac_busy) begin
					state_d = SEQ_IDLE;
					done    = 1'b1;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (issue) begin
			if (k_end) begin
				k_q <= '0;
				if (j_end) begin
					j_q <= '0;
					i_q <= i_end ? '0 : i_q + IW'(1);
				end else begin
					j_q <= j_q + IW'(1);
				end
			end else begin
				k_q <= k_q + IW'(1);
			end
		end
	end

	always_comb begin
		ctl.valid   = issue;
		ctl.phase2  = (state_q == SEQ_PH2);
		ctl.first   = (k_q == '0);
		ctl.last    = k_end;
		// first phase sums k from i upward, second adds A^T*A for k up to i
		ctl.term_en = ctl.phase2 ? (k_q <= i_q) : (k_q >= i_q);
		waddr       = {i_q, j_q};
		a0_raddr    = ctl.phase2 ? {k_q, i_q} : {i_q, k_q};
		a1_raddr    = {k_q, j_q};
		b_raddr     = ctl.phase2 ? {j_q, k_q} : {k_q, j_q};
		ab_raddr    = {i_q, k_q};
	end
endmodule

FILE: src/tabbt_mac.sv
// ----------------------------------------------------------------------------
// tabbt_mac
// Multiply-accumulate pipeline: products, term sum, accumulate and write back.
// ----------------------------------------------------------------------------
module tabbt_mac import tabbt_pkg::*; #(
	parameter int AW = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctl_t                 ctl_in,
	input  logic [AW-1:0]            waddr_in,
	input  logic signed [VAL_W-1:0]  a0_rdata,
	input  logic signed [VAL_W-1:0]  a1_rdata,
	input  logic signed [VAL_W-1:0]  b_rdata,
	input  logic signed [AB_W-1:0]   ab_rdata,
	output logic                     ab_we,
	output logic                     c_we,
	output logic [AW-1:0]            wr_addr,
	output logic [AB_W-1:0]          ab_wdata,
	output logic [DATA_W-1:0]        c_wdata,
	output logic                     busy
);
	localparam int P1_W = AB_W + VAL_W;
	localparam int P2_W = 2 * VAL_W;

	mac_ctl_t                 ctl_s1, ctl_s2, ctl_s3;
	logic [AW-1:0]            waddr_s1, waddr_s2, waddr_s3;
	logic signed [AB_W-1:0]   opx;
	logic signed [P1_W-1:0]   m1, p1_s2;
	logic signed [P2_W-1:0]   m2, p2_s2;
	logic signed [DATA_W-1:0] term_s3, acc_q, acc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	assign opx = ctl_s1.phase2 ? ab_rdata : AB_W'(a0_rdata);
	assign m1  = opx * b_rdata;
	assign m2  = a0_rdata * a1_rdata;

	always_ff @(posedge clk) begin
		waddr_s1 <= waddr_in;
		waddr_s2 <= waddr_s1;
		waddr_s3 <= waddr_s2;
		// drop the terms outside the triangle
		p1_s2    <= (!ctl_s1.phase2 && !ctl_s1.term_en) ? '0 : m1;
		p2_s2    <= (ctl_s1.phase2 && ctl_s1.term_en) ? m2 : '0;
		term_s3  <= DATA_W'(p1_s2) + DATA_W'(p2_s2);
		if (ctl_s3.valid) begin
			acc_q <= acc_d;
		end
	end

	assign acc_d    = (ctl_s3.first ? '0 : acc_q) + term_s3;
	assign ab_we    = ctl_s3.valid && ctl_s3.last && !ctl_s3.phase2;
	assign c_we     = ctl_s3.valid && ctl_s3.last && ctl_s3.phase2;
	assign wr_addr  = waddr_s3;
	assign ab_wdata = acc_d[AB_W-1:0];
	assign c_wdata  = acc_d;
	assign busy     = ctl_s1.valid || ctl_s2.valid || ctl_s3.valid;
endmodule
